@@ design/psq_pkg.sv @@
package psq_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int OCC_W   = 7;

    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_AT    = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_AT    = 3'd5,
        FN_DUMP      = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        S_OK    = 2'd0,
        S_RANGE = 2'd1,
        S_EMPTY = 2'd2,
        S_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CO_HOLD = 2'd0,
        CO_INS  = 2'd1,
        CO_DEL  = 2'd2,
        CO_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  element;
        logic [OCC_W-1:0]           occupancy;
        logic                       last;
    } t_result;

endpackage

@@ design/psq_cell.sv @@
module psq_cell #(
    parameter int CAPACITY = psq_pkg::DEF_CAPACITY,
    parameter int INDEX    = 0,
    parameter int FW       = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  psq_pkg::t_cell_op                 i_op,
    input  logic [FW-1:0]                     i_idx,
    input  logic [FW-1:0]                     i_fill,
    input  logic signed [psq_pkg::VALUE_W-1:0] i_value,
    input  logic signed [psq_pkg::VALUE_W-1:0] i_left,
    input  logic signed [psq_pkg::VALUE_W-1:0] i_right,
    input  logic signed [psq_pkg::VALUE_W-1:0] i_head,
    output logic signed [psq_pkg::VALUE_W-1:0] o_value
);

    localparam logic [FW:0] IDX = (FW + 1)'(INDEX);

    logic signed [psq_pkg::VALUE_W-1:0] r_value;
    logic signed [psq_pkg::VALUE_W-1:0] n_value;
    logic [FW:0]                        idx_e;
    logic [FW:0]                        fill_e;

    assign idx_e  = {1'b0, i_idx};
    assign fill_e = {1'b0, i_fill};

    always_comb begin
        n_value = r_value;
        unique case (i_op)
            psq_pkg::CO_INS: begin
                // new word lands here, later ones move up
                if (IDX == idx_e) begin
                    n_value = i_value;
                end else if (IDX > idx_e && IDX <= fill_e) begin
                    n_value = i_left;
                end
            end
            psq_pkg::CO_DEL: begin
                if (IDX >= idx_e && (IDX + 1'b1) < fill_e) begin
                    n_value = i_right;
                end
            end
            psq_pkg::CO_ROT: begin
                // rotate the occupied part by one, head wraps to the tail
                if ((IDX + 1'b1) < fill_e) begin
                    n_value = i_right;
                end else if ((IDX + 1'b1) == fill_e) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ design/psq_chain.sv @@
module psq_chain #(
    parameter int CAPACITY = psq_pkg::DEF_CAPACITY,
    parameter int FW       = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  psq_pkg::t_cell_op                 i_op,
    input  logic [FW-1:0]                     i_idx,
    input  logic [FW-1:0]                     i_fill,
    input  logic signed [psq_pkg::VALUE_W-1:0] i_value,
    output logic signed [psq_pkg::VALUE_W-1:0] o_head
);

    logic signed [psq_pkg::VALUE_W-1:0] cell_q [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [psq_pkg::VALUE_W-1:0] left_d;
        logic signed [psq_pkg::VALUE_W-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_q[g+1];
        end

        psq_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g),
            .FW       (FW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_idx   (i_idx),
            .i_fill  (i_fill),
            .i_value (i_value),
            .i_left  (left_d),
            .i_right (right_d),
            .i_head  (cell_q[0]),
            .o_value (cell_q[g])
        );
    end

    assign o_head = cell_q[0];

endmodule

@@ design/psq_out_queue.sv @@
module psq_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  psq_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output psq_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_v0;
    logic             r_v1;
    logic             n_v0;
    logic             n_v1;
    psq_pkg::t_result r_d0;
    psq_pkg::t_result r_d1;
    psq_pkg::t_result n_d0;
    psq_pkg::t_result n_d1;
    logic             pop;
    logic             push;

    assign pop  = r_v0 && i_ready;
    assign push = i_push && !r_v1;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (pop) begin
            if (r_v1) begin
                // advance the skid word to the front
                n_d0 = r_d1;
                n_v1 = 1'b0;
            end else if (push) begin
                n_d0 = i_data;
            end else begin
                n_v0 = 1'b0;
            end
        end else if (push) begin
            if (!r_v0) begin
                n_d0 = i_data;
                n_v0 = 1'b1;
            end else begin
                n_d1 = i_data;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_data  = r_d0;

endmodule

@@ design/positional_sequence_store_unit.sv @@
// Ordered store of up to CAPACITY signed 32-bit words held in a row of cells.
// Input channel (i_in_valid / o_in_ready) carries one operation per word:
// insert front/back/at position, delete front/back/at position, or dump.
// Output channel (o_out_valid / i_out_ready) carries result words with
// status, element, occupancy after the operation and a last mark.
// Insert and delete finish in the accept cycle: every cell compares its
// index with the target slot and shifts toward its neighbor, so these
// operations run at one word per cycle while o_in_ready is high. The result
// is registered in the output queue.
// A dump of n elements gives n words and holds o_in_ready low meanwhile:
// the occupied cells rotate by one place per emitted word, the head cell
// feeding the output, so the first element passes the dump state and the
// output queue, and o_in_ready returns once the last one is queued. An empty
// dump gives one word.
// The output side is a two-word register queue, so one new operation is
// taken while a result waits; when the receiver stalls with both words held,
// o_in_ready drops and the rotation pauses.
// Reset clears the element count and the output queue; cell contents need no
// clearing since only cells below the count are ever read.
module positional_sequence_store_unit #(
    parameter int CAPACITY = psq_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_func,
    input  logic [psq_pkg::POS_W-1:0]           i_position,
    input  logic signed [psq_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [psq_pkg::VALUE_W-1:0]  o_element,
    output logic [psq_pkg::OCC_W-1:0]           o_occupancy,
    output logic                                o_last
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = ((FW > psq_pkg::POS_W) ? FW : psq_pkg::POS_W) + 1;
    localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

    typedef enum logic [1:0] {
        CS_IDLE = 2'b01,
        CS_DUMP = 2'b10
    } t_state;

    t_state                             r_state;
    t_state                             n_state;
    logic [FW-1:0]                      r_fill;
    logic [FW-1:0]                      n_fill;
    logic [FW-1:0]                      r_cnt;
    logic [FW-1:0]                      n_cnt;

    psq_pkg::t_cell_op                  cell_op;
    logic [FW-1:0]                      cell_idx;
    logic signed [psq_pkg::VALUE_W-1:0] head;
    logic                               accept;
    logic                               q_full;
    logic                               push;
    psq_pkg::t_result                   push_data;
    psq_pkg::t_result                   out_data;
    logic [CW-1:0]                      pos_e;
    logic [CW-1:0]                      fill_e;

    assign accept = i_in_valid && o_in_ready;
    assign pos_e  = CW'(i_position);
    assign fill_e = CW'(r_fill);

    always_comb begin
        psq_pkg::t_status st;
        logic             is_empty;
        logic             is_full;

        is_empty  = (r_fill == '0);
        is_full   = (r_fill == CAP_F);
        st        = psq_pkg::S_OK;
        n_state   = r_state;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        cell_op   = psq_pkg::CO_HOLD;
        cell_idx  = '0;
        push      = 1'b0;
        push_data = '0;

        unique case (r_state)
            CS_IDLE: begin
                if (accept) begin
                    push = 1'b1;
                    unique case (psq_pkg::t_func'(i_func))
                        psq_pkg::FN_INS_FRONT: begin
                            if (is_full) begin
                                st = psq_pkg::S_FULL;
                            end else begin
                                cell_op = psq_pkg::CO_INS;
                                n_fill  = r_fill + 1'b1;
                            end
                        end
                        psq_pkg::FN_INS_BACK: begin
                            if (is_full) begin
                                st = psq_pkg::S_FULL;
                            end else begin
                                cell_op  = psq_pkg::CO_INS;
                                cell_idx = r_fill;
                                n_fill   = r_fill + 1'b1;
                            end
                        end
                        psq_pkg::FN_INS_AT: begin
                            // range check ranks ahead of the full check
                            if (pos_e == '0 || pos_e > fill_e + 1'b1) begin
                                st = psq_pkg::S_RANGE;
                            end else if (is_full) begin
                                st = psq_pkg::S_FULL;
                            end else begin
                                cell_op  = psq_pkg::CO_INS;
                                cell_idx = FW'(pos_e - 1'b1);
                                n_fill   = r_fill + 1'b1;
                            end
                        end
                        psq_pkg::FN_DEL_FRONT: begin
                            if (is_empty) begin
                                st = psq_pkg::S_EMPTY;
                            end else begin
                                cell_op = psq_pkg::CO_DEL;
                                n_fill  = r_fill - 1'b1;
                            end
                        end
                        psq_pkg::FN_DEL_BACK: begin
                            if (is_empty) begin
                                st = psq_pkg::S_EMPTY;
                            end else begin
                                cell_op  = psq_pkg::CO_DEL;
                                cell_idx = r_fill - 1'b1;
                                n_fill   = r_fill - 1'b1;
                            end
                        end
                        psq_pkg::FN_DEL_AT: begin
                            if (pos_e == '0 || pos_e > fill_e) begin
                                st = psq_pkg::S_RANGE;
                            end else begin
                                cell_op  = psq_pkg::CO_DEL;
                                cell_idx = FW'(pos_e - 1'b1);
                                n_fill   = r_fill - 1'b1;
                            end
                        end
                        psq_pkg::FN_DUMP: begin
                            if (is_empty) begin
                                st = psq_pkg::S_EMPTY;
                            end else begin
                                // words come out of the rotation, not here
                                push    = 1'b0;
                                n_cnt   = r_fill;
                                n_state = CS_DUMP;
                            end
                        end
                        default: begin
                            st = psq_pkg::S_OK;
                        end
                    endcase
                    push_data.status    = st;
                    push_data.element   = '0;
                    push_data.occupancy = psq_pkg::OCC_W'(n_fill);
                    push_data.last      = 1'b1;
                end
            end
            CS_DUMP: begin
                if (!q_full) begin
                    push                = 1'b1;
                    cell_op             = psq_pkg::CO_ROT;
                    push_data.status    = psq_pkg::S_OK;
                    push_data.element   = head;
                    push_data.occupancy = psq_pkg::OCC_W'(r_fill);
                    push_data.last      = (r_cnt == FW'(1));
                    n_cnt               = r_cnt - 1'b1;
                    if (r_cnt == FW'(1)) begin
                        n_state = CS_IDLE;
                    end
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    psq_chain #(
        .CAPACITY (CAPACITY),
        .FW       (FW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_op    (cell_op),
        .i_idx   (cell_idx),
        .i_fill  (r_fill),
        .i_value (i_value),
        .o_head  (head)
    );

    psq_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_ready (i_out_ready)
    );

    assign o_in_ready  = (r_state == CS_IDLE) && !q_full;
    assign o_status    = out_data.status;
    assign o_element   = out_data.element;
    assign o_occupancy = out_data.occupancy;
    assign o_last      = out_data.last;

endmodule

@@ design/psq_checker.sv @@
module psq_checker #(
    parameter int CAPACITY = psq_pkg::DEF_CAPACITY
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [2:0]                          i_func,
    input logic [psq_pkg::POS_W-1:0]           i_position,
    input logic signed [psq_pkg::VALUE_W-1:0]  i_value,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [1:0]                          o_status,
    input logic signed [psq_pkg::VALUE_W-1:0]  o_element,
    input logic [psq_pkg::OCC_W-1:0]           o_occupancy,
    input logic                                o_last
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_element)
            && $stable(o_status) && $stable(o_last))
        else $error("result word changed while stalled");

    a_occ_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_occupancy) <= CAPACITY)
        else $error("occupancy above capacity");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == psq_pkg::S_EMPTY |-> o_occupancy == '0 && o_last)
        else $error("empty status with elements or without last");

    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != psq_pkg::S_OK |-> o_element == '0)
        else $error("element nonzero on an error result");

    // a dump in progress blocks new operations
    a_dump_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("operation accepted in the middle of a dump");

endmodule

bind positional_sequence_store_unit psq_checker #(.CAPACITY(CAPACITY)) u_psq_checker (.*);

@@ tb/sv/tb_positional_sequence_store_unit.sv @@
`timescale 1ns / 100ps

module tb_positional_sequence_store_unit;

    localparam int CLK_PERIOD   = 8;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int RAND_ITEMS   = 210;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [2:0] FN_NOP = 3'd7;

    typedef enum int {PH_GROW, PH_MIX, PH_SHRINK} t_phase;

    typedef struct packed {
        logic [2:0]                         fn;
        logic [psq_pkg::POS_W-1:0]          pos;
        logic signed [psq_pkg::VALUE_W-1:0] val;
        bit                                 typed;
        psq_pkg::t_status                   st;
        logic [psq_pkg::OCC_W-1:0]          occ;
    } t_op_row;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [2:0]                         i_func;
    logic [psq_pkg::POS_W-1:0]          i_position;
    logic signed [psq_pkg::VALUE_W-1:0] i_value;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [1:0]                         o_status;
    logic signed [psq_pkg::VALUE_W-1:0] o_element;
    logic [psq_pkg::OCC_W-1:0]          o_occupancy;
    logic                               o_last;

    // shadow copy of the sequence, packed from slot 0
    logic signed [psq_pkg::VALUE_W-1:0] shadow_slots [0:psq_pkg::DEF_CAPACITY-1];
    int                                 shadow_fill;
    psq_pkg::t_result                   pending_results [$];
    t_op_row                            dir_table [$];
    int                                 err_cnt;
    int                                 results_seen;

    positional_sequence_store_unit #(
        .CAPACITY(psq_pkg::DEF_CAPACITY)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_occupancy (o_occupancy),
        .o_last      (o_last)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void expect_word(psq_pkg::t_status st,
                                        logic signed [psq_pkg::VALUE_W-1:0] el,
                                        logic last);
        psq_pkg::t_result r;
        r.status    = st;
        r.element   = el;
        r.occupancy = psq_pkg::OCC_W'(shadow_fill);
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    function automatic psq_pkg::t_status insert_word(int idx,
                                                     logic signed [psq_pkg::VALUE_W-1:0] v);
        if (shadow_fill >= psq_pkg::DEF_CAPACITY) return psq_pkg::S_FULL;
        for (int i = shadow_fill; i > idx; i--)
            shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[idx] = v;
        shadow_fill++;
        return psq_pkg::S_OK;
    endfunction

    function automatic void remove_word(int idx);
        for (int i = idx; i + 1 < shadow_fill; i++)
            shadow_slots[i] = shadow_slots[i+1];
        shadow_fill--;
    endfunction

    // Update the shadow store for one accepted word and queue its results.
    function automatic void apply_op(t_op_row w);
        psq_pkg::t_status st;
        int               p;
        bit               push;
        st   = psq_pkg::S_OK;
        p    = int'(w.pos);
        push = !w.typed;
        case (w.fn)
            psq_pkg::FN_INS_FRONT: st = insert_word(0, w.val);
            psq_pkg::FN_INS_BACK:  st = insert_word(shadow_fill, w.val);
            psq_pkg::FN_INS_AT: begin
                if (p < 1 || p > shadow_fill + 1) st = psq_pkg::S_RANGE;
                else st = insert_word(p - 1, w.val);
            end
            psq_pkg::FN_DEL_FRONT: begin
                if (shadow_fill == 0) st = psq_pkg::S_EMPTY;
                else remove_word(0);
            end
            psq_pkg::FN_DEL_BACK: begin
                if (shadow_fill == 0) st = psq_pkg::S_EMPTY;
                else remove_word(shadow_fill - 1);
            end
            psq_pkg::FN_DEL_AT: begin
                if (p < 1 || p > shadow_fill) st = psq_pkg::S_RANGE;
                else remove_word(p - 1);
            end
            psq_pkg::FN_DUMP: begin
                if (shadow_fill == 0) st = psq_pkg::S_EMPTY;
                else if (push) begin
                    for (int i = 0; i < shadow_fill; i++)
                        expect_word(psq_pkg::S_OK, shadow_slots[i], i == shadow_fill - 1);
                    return;
                end
            end
            default: st = psq_pkg::S_OK;
        endcase
        if (push) begin
            expect_word(st, '0, 1'b1);
        end else begin
            pending_results.push_back({w.st, {psq_pkg::VALUE_W{1'b0}}, w.occ, 1'b1});
        end
    endfunction

    function automatic void add_row(logic [2:0] fn, int pos,
                                    logic signed [psq_pkg::VALUE_W-1:0] val,
                                    bit typed, psq_pkg::t_status st, int occ);
        t_op_row w;
        w.fn    = fn;
        w.pos   = psq_pkg::POS_W'(pos);
        w.val   = val;
        w.typed = typed;
        w.st    = st;
        w.occ   = psq_pkg::OCC_W'(occ);
        dir_table.push_back(w);
    endfunction

    function automatic logic [2:0] pick_func(t_phase ph);
        int ins_pct;
        int del_pct;
        int r;
        case (ph)
            PH_GROW: begin
                ins_pct = 86;
                del_pct = 8;
            end
            PH_MIX: begin
                ins_pct = 44;
                del_pct = 46;
            end
            default: begin
                ins_pct = 12;
                del_pct = 82;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            case ($urandom_range(0, 2))
                0:       return psq_pkg::FN_INS_FRONT;
                1:       return psq_pkg::FN_INS_BACK;
                default: return psq_pkg::FN_INS_AT;
            endcase
        end
        if (r < ins_pct + del_pct) begin
            case ($urandom_range(0, 2))
                0:       return psq_pkg::FN_DEL_FRONT;
                1:       return psq_pkg::FN_DEL_BACK;
                default: return psq_pkg::FN_DEL_AT;
            endcase
        end
        if (r < 97) return psq_pkg::FN_DUMP;
        return FN_NOP;
    endfunction

    function automatic logic [psq_pkg::POS_W-1:0] pick_position(logic [2:0] fn);
        int hi;
        hi = (fn == psq_pkg::FN_INS_AT) ? shadow_fill + 1 : shadow_fill;
        if (hi > 0 && $urandom_range(0, 99) < 80)
            return psq_pkg::POS_W'($urandom_range(1, hi));
        return psq_pkg::POS_W'($urandom_range(0, 127));
    endfunction

    function automatic logic signed [psq_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one word, hold it until accepted, then predict its results.
    task automatic send_word(input t_op_row w, input bit quiet);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= w.fn;
        i_position <= w.pos;
        i_value    <= w.val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_op(w);
        @(negedge i_clk);
    endtask

    // receiver: random stalls, calm windows, and one long hold-off
    initial begin : rx_side
        int  rx_hold_cnt;
        int  rx_run_cnt;
        int  rx_cycle;
        bit  long_hold_done;
        rx_hold_cnt    = 0;
        rx_run_cnt     = 0;
        rx_cycle       = 0;
        long_hold_done = 0;
        i_out_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (!long_hold_done && results_seen >= 40) begin
                rx_hold_cnt    = HOLD_CYCLES;
                rx_run_cnt     = 0;
                long_hold_done = 1;
            end
            if (rx_hold_cnt == 0 && rx_run_cnt == 0) begin
                rx_hold_cnt = (((rx_cycle / 150) % 4) == 2) ? 0 : idle_len();
                rx_run_cnt  = $urandom_range(1, 12);
            end
            if (rx_hold_cnt != 0) begin
                i_out_ready <= 1'b0;
                rx_hold_cnt--;
            end else begin
                i_out_ready <= 1'b1;
                rx_run_cnt--;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        psq_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word status %0d element %0d occ %0d",
                                          o_status, o_element, o_occupancy));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_element !== want.element)
                    report_mismatch($sformatf("element %0d, want %0d",
                                              o_element, want.element));
                if (o_occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              o_occupancy, want.occupancy));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
        end
    end

    initial begin : run_limit
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb_positional_sequence_store_unit NOT OK");
        $finish;
    end

    initial begin : main_seq
        t_op_row w;
        t_phase  ph;
        int      full_hits;
        int      mix_end;
        err_cnt      = 0;
        results_seen = 0;
        shadow_fill  = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = psq_pkg::FN_INS_FRONT;
        i_position   = '0;
        i_value      = '0;

        // empty-store errors and range checks first, then a short build and teardown
        add_row(psq_pkg::FN_DUMP,      0,   0,              1, psq_pkg::S_EMPTY, 0);
        add_row(psq_pkg::FN_DEL_FRONT, 0,   0,              1, psq_pkg::S_EMPTY, 0);
        add_row(psq_pkg::FN_DEL_BACK,  0,   0,              1, psq_pkg::S_EMPTY, 0);
        add_row(psq_pkg::FN_DEL_AT,    1,   0,              1, psq_pkg::S_RANGE, 0);
        add_row(psq_pkg::FN_INS_AT,    0,   32'sd5,         1, psq_pkg::S_RANGE, 0);
        add_row(psq_pkg::FN_INS_AT,    2,   32'sd6,         1, psq_pkg::S_RANGE, 0);
        add_row(FN_NOP,                0,   0,              1, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_INS_FRONT, 0,   32'sh7fff_ffff, 1, psq_pkg::S_OK,    1);
        add_row(psq_pkg::FN_INS_BACK,  0,   32'sh8000_0000, 1, psq_pkg::S_OK,    2);
        add_row(psq_pkg::FN_INS_AT,    2,   -32'sd1,        0, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_INS_AT,    4,   32'sd0,         0, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_INS_AT,    127, 32'sh5a5a_5a5a, 1, psq_pkg::S_RANGE, 4);
        add_row(psq_pkg::FN_INS_AT,    6,   32'sh1234_5678, 1, psq_pkg::S_RANGE, 4);
        add_row(psq_pkg::FN_DUMP,      0,   0,              0, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_DEL_AT,    0,   0,              1, psq_pkg::S_RANGE, 4);
        add_row(psq_pkg::FN_DEL_AT,    5,   0,              1, psq_pkg::S_RANGE, 4);
        add_row(psq_pkg::FN_DEL_AT,    127, 0,              1, psq_pkg::S_RANGE, 4);
        add_row(psq_pkg::FN_DEL_AT,    2,   0,              0, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_DEL_FRONT, 0,   0,              0, psq_pkg::S_OK,    0);
        add_row(FN_NOP,                127, -32'sd1,        1, psq_pkg::S_OK,    2);
        add_row(psq_pkg::FN_DEL_BACK,  0,   0,              0, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_DUMP,      0,   0,              0, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_DEL_AT,    1,   0,              0, psq_pkg::S_OK,    0);
        add_row(psq_pkg::FN_DUMP,      0,   0,              1, psq_pkg::S_EMPTY, 0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k])
            send_word(dir_table[k], 1'b0);

        // fill to capacity, poke the full store, mix, then drain
        ph        = PH_GROW;
        full_hits = 0;
        mix_end   = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (ph == PH_GROW && (full_hits >= 12 || n >= 150)) begin
                ph      = PH_MIX;
                mix_end = n + 30;
            end
            if (ph == PH_MIX && n >= mix_end) ph = PH_SHRINK;
            if (shadow_fill == psq_pkg::DEF_CAPACITY) full_hits++;
            w       = '0;
            w.fn    = pick_func(ph);
            w.pos   = pick_position(w.fn);
            w.val   = pick_value();
            w.typed = 1'b0;
            send_word(w, ((n / 32) % 4) == 3);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("tb_positional_sequence_store_unit OK");
        end else begin
            $display("tb_positional_sequence_store_unit NOT OK");
        end
        $finish;
    end

endmodule
